// ===== rtl/ohash_pkg.sv =====
package ohash_pkg;

    // Table geometry. TABLE_SIZE must be a power of two.
    localparam int TABLE_SIZE = 256;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE) + 1;

    // A new key is refused once the count reaches floor(2 * size / 3).
    localparam int LOAD_LIMIT = (2 * TABLE_SIZE) / 3;

    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int PERTURB_W  = 32;
    localparam int SHIFT_STEP = 5;

    localparam int STATUS_W   = 2;
    localparam int ENTRY_W    = 9;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 48;

    // Commands carried on s_tuser.
    localparam logic CMD_SET    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Result status carried on m_tuser.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Write request into the slot store.
    typedef struct packed {
        logic               en;
        logic               fill;   // claims an empty slot: sets valid and key
        logic [ADDR_W-1:0]  addr;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_wr_t;

    // Registered read data from the slot store.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_rd_t;

endpackage

// ===== rtl/ohash_step.sv =====
module ohash_step (
    input  logic [ohash_pkg::ADDR_W-1:0]    idx,
    input  logic [ohash_pkg::PERTURB_W-1:0] perturb,
    output logic [ohash_pkg::ADDR_W-1:0]    idx_next,
    output logic [ohash_pkg::PERTURB_W-1:0] perturb_next
);
    import ohash_pkg::*;

    // Only the low address bits of the index ever reach a slot, so the
    // recurrence idx = 5 * idx + perturb + 1 is kept at slot width.
    always_comb begin
        idx_next     = ADDR_W'(idx << 2) + idx + ADDR_W'(perturb) + ADDR_W'(1);
        perturb_next = perturb >> SHIFT_STEP;
    end

endmodule

// ===== rtl/ohash_store.sv =====
module ohash_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [ohash_pkg::ADDR_W-1:0]  rd_addr,
    output ohash_pkg::slot_rd_t           rd_data,
    input  ohash_pkg::slot_wr_t           wr_req
);
    import ohash_pkg::*;

    logic [TABLE_SIZE-1:0] valid_reg;
    logic [KEY_W-1:0]      key_mem [TABLE_SIZE];
    logic [VALUE_W-1:0]    value_mem [TABLE_SIZE];
    slot_rd_t              rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_req.en && wr_req.fill) begin
            valid_reg[wr_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            value_mem[wr_req.addr] <= wr_req.value;
            if (wr_req.fill) begin
                key_mem[wr_req.addr] <= wr_req.key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg.valid <= valid_reg[rd_addr];
            rd_reg.key   <= key_mem[rd_addr];
            rd_reg.value <= value_mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

// ===== rtl/open_address_hash_table_top.sv =====
// Key-value table of ohash_pkg::TABLE_SIZE slots with 32-bit keys and values,
// open addressing and perturbation probing. Each input transaction carries a
// command on s_tuser (set or look up), the key and the value to store. Each
// transaction yields exactly one result transaction carrying a status on
// m_tuser (ok, key not found, table full), the found value, a flag for a
// newly filled slot and the number of occupied slots. One shared probe-step
// unit walks the probe sequence and the key and value memories are read
// once per cycle, so probes are issued one per cycle. A search ends at a
// matching slot, or at an empty slot for a set, or when all TABLE_SIZE
// probes find nothing; a lookup of an absent key always walks all
// TABLE_SIZE probes. The block accepts a new transaction only when it is
// idle. It becomes ready in the same cycle that the result is offered. A
// finished result waits until the output register is free, and it is held
// there until the downstream side takes it. The slot-valid bits clear in the
// reset cycle itself, so no clearing pass is needed.
module open_address_hash_table_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ohash_pkg::S_DATA_W-1:0]    s_tdata,  // [31:0] item_key,
                                                        // [63:32] store_value
    input  logic                              s_tuser,  // [0] cmd
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ohash_pkg::M_DATA_W-1:0]    m_tdata,  // [31:0] found_value,
                                                        // [32] inserted_new,
                                                        // [41:33] entry_count,
                                                        // [47:42] zero
    output logic [ohash_pkg::STATUS_W-1:0]    m_tuser   // [1:0] status
);
    import ohash_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_PROBE  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Operation context captured on acceptance.
    logic                     cmd_reg;
    logic signed [KEY_W-1:0]  item_key_reg;
    logic [VALUE_W-1:0]       store_value_reg;

    // Probe sequencer.
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [PERTURB_W-1:0] perturb_reg, perturb_next;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [ADDR_W-1:0]    rd_slot_reg, rd_slot_next;
    logic [ADDR_W-1:0]    step_idx;
    logic [PERTURB_W-1:0] step_perturb;

    logic [CNT_W-1:0]     count_reg, count_next;

    // Result waiting to move into the output register.
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [VALUE_W-1:0]   res_value_reg, res_value_next;
    logic                 res_new_reg, res_new_next;
    logic [ENTRY_W-1:0]   res_entry_reg, res_entry_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 out_new_reg;
    logic [ENTRY_W-1:0]   out_entry_reg;

    logic                 in_accept;
    logic                 issue;
    logic                 hit_match;
    logic                 hit_empty;
    logic                 fail;
    logic                 out_free;
    logic [PERTURB_W-1:0] in_hash;
    slot_rd_t             rd_data;
    slot_wr_t             wr_req;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_tready;

    // Key zero hashes to all ones; every other key hashes to itself.
    assign in_hash = (s_tdata[KEY_W-1:0] == '0) ? '1 : s_tdata[KEY_W-1:0];

    ohash_step u_step (
        .idx          (idx_reg),
        .perturb      (perturb_reg),
        .idx_next     (step_idx),
        .perturb_next (step_perturb)
    );

    ohash_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (issue),
        .rd_addr (step_idx),
        .rd_data (rd_data),
        .wr_req  (wr_req)
    );

    // A read is issued on every probing cycle until the probe budget is
    // spent; its data is compared in the next cycle, so probes overlap.
    assign issue     = (state_reg == ST_PROBE) && (issue_cnt_reg < CNT_W'(TABLE_SIZE));
    assign hit_match = rd_pend_reg && rd_data.valid && (rd_data.key == item_key_reg);
    assign hit_empty = rd_pend_reg && !rd_data.valid && (cmd_reg == CMD_SET);
    assign fail      = !rd_pend_reg && !issue;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        perturb_next    = perturb_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_pend_next    = rd_pend_reg;
        rd_slot_next    = rd_slot_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_new_next    = res_new_reg;
        res_entry_next  = res_entry_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        wr_req          = '0;
        wr_req.addr     = rd_slot_reg;
        wr_req.key      = item_key_reg;
        wr_req.value    = store_value_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    idx_next       = in_hash[ADDR_W-1:0];
                    perturb_next   = in_hash;
                    issue_cnt_next = '0;
                    rd_pend_next   = 1'b0;
                    state_next     = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (issue) begin
                    idx_next       = step_idx;
                    perturb_next   = step_perturb;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    rd_slot_next   = step_idx;
                end
                rd_pend_next    = issue;
                res_status_next = ST_OK;
                res_value_next  = '0;
                res_new_next    = 1'b0;
                if (hit_match || hit_empty || fail) begin
                    state_next = ST_FINISH;
                    if (fail) begin
                        res_status_next = (cmd_reg == CMD_SET) ? ST_FULL : ST_NOT_FOUND;
                    end else if (cmd_reg == CMD_LOOKUP) begin
                        res_value_next = rd_data.value;
                    end else if (hit_match) begin
                        // Update of a key already present.
                        wr_req.en = 1'b1;
                    end else if (count_reg >= CNT_W'(LOAD_LIMIT)) begin
                        res_status_next = ST_FULL;
                    end else begin
                        wr_req.en    = 1'b1;
                        wr_req.fill  = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                        res_new_next = 1'b1;
                    end
                    res_entry_next = ENTRY_W'(count_next);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg         <= s_tuser;
            item_key_reg    <= signed'(s_tdata[KEY_W-1:0]);
            store_value_reg <= s_tdata[KEY_W+VALUE_W-1:KEY_W];
        end
        idx_reg        <= idx_next;
        perturb_reg    <= perturb_next;
        issue_cnt_reg  <= issue_cnt_next;
        rd_slot_reg    <= rd_slot_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_new_reg    <= res_new_next;
        res_entry_reg  <= res_entry_next;
        if (state_reg == ST_FINISH && out_free) begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_new_reg    <= res_new_reg;
            out_entry_reg  <= res_entry_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(M_DATA_W - VALUE_W - 1 - ENTRY_W)'(0),
                       out_entry_reg, out_new_reg, out_value_reg};

endmodule

// ===== rtl/ohash_checker.sv =====
module ohash_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [ohash_pkg::S_DATA_W-1:0]    s_tdata,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ohash_pkg::M_DATA_W-1:0]    m_tdata,
    input logic [ohash_pkg::STATUS_W-1:0]    m_tuser
);
    import ohash_pkg::*;

    logic unused_in;
    assign unused_in = ^{s_tdata, s_tuser};

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The block works on one transaction at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOT_FOUND || m_tuser == ST_FULL))
        else $error("undefined status code");

    a_new_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[VALUE_W] |-> m_tuser == ST_OK)
        else $error("new slot reported on a failed operation");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[VALUE_W-1:0] == '0)
        else $error("nonzero value on a failed operation");

endmodule

bind open_address_hash_table_top ohash_checker u_ohash_checker (.*);
